// ===== rtl/core/slt_pkg.sv =====
// Shared constants, codes and types for the sorted list table.
`default_nettype none

package slt_pkg;

  localparam int CAPACITY = 16;
  localparam int VALUE_W  = 32;
  localparam int REQ_W    = 2;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

  // Command broadcast to every cell of the chain
  typedef struct packed {
    logic                      ins;
    logic                      del;
    logic signed [VALUE_W-1:0] value;
  } slt_bcast_t;

  // What a cell shows its neighbours and the control
  typedef struct packed {
    logic                      valid;
    logic                      ge;
    logic                      eq;
    logic signed [VALUE_W-1:0] value;
  } slt_cell_out_t;

endpackage

`default_nettype wire

// ===== rtl/core/slt_cell.sv =====
// One slot of the sorted chain: holds a value and shifts to or from its neighbours.
`default_nettype none

module slt_cell (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire slt_pkg::slt_bcast_t   bcast,
  input  wire slt_pkg::slt_cell_out_t left,
  input  wire slt_pkg::slt_cell_out_t right,
  output slt_pkg::slt_cell_out_t     cell_o
);

  logic signed [slt_pkg::VALUE_W-1:0] value_r;
  logic signed [slt_pkg::VALUE_W-1:0] value_nxt;
  logic                               valid_r;
  logic                               valid_nxt;
  logic                               ge;
  logic                               eq;

  // An empty slot counts as "at or above" so an insert lands at the end of the run
  assign ge = !valid_r || (value_r >= bcast.value);
  assign eq = valid_r && (value_r == bcast.value);

  assign cell_o.valid = valid_r;
  assign cell_o.ge    = ge;
  assign cell_o.eq    = eq;
  assign cell_o.value = value_r;

  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    if (bcast.ins) begin
      valid_nxt = valid_r || left.valid;
      if (ge) begin
        // take the left neighbour past the insert point, the new value at it
        value_nxt = left.ge ? left.value : bcast.value;
      end
    end else if (bcast.del) begin
      if (valid_r && ge) begin
        value_nxt = right.value;
        valid_nxt = right.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sorted_list_table.sv =====
// Top level of the sorted list table: request register, cell chain and result register.
//
//  channel  direction  handshake           payload
//  in_      to block   in_valid/in_stall   in_req_type[1:0], in_value[31:0] signed
//  out_     from block out_valid/out_stall out_status[1:0], out_occupancy[4:0]
//
// A beat is registered on acceptance and executed by every cell in the next cycle,
// which also registers its result; no new request is taken while one executes.
// The chain compares in parallel and shifts one slot in that execute cycle.
// Reset clears every valid bit, which empties the table; slot contents are not reset and matter only while valid.
// A stalled result holds in the output register and blocks new requests.
`default_nettype none

module sorted_list_table (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [slt_pkg::REQ_W-1:0]           in_req_type,
  input  wire logic signed [slt_pkg::VALUE_W-1:0]  in_value,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [slt_pkg::STATUS_W-1:0]             out_status,
  output logic [slt_pkg::OCC_W-1:0]                out_occupancy
);

  localparam int N = slt_pkg::CAPACITY;

  logic                               pend_r;
  logic [slt_pkg::REQ_W-1:0]          req_r;
  logic signed [slt_pkg::VALUE_W-1:0] val_r;
  logic                               out_valid_r;
  logic [slt_pkg::STATUS_W-1:0]       status_r;
  logic [slt_pkg::STATUS_W-1:0]       status_nxt;
  logic [slt_pkg::CNT_W-1:0]          count_r;
  logic [slt_pkg::CNT_W-1:0]          count_nxt;
  logic                               in_acc;

  slt_pkg::slt_bcast_t    bcast;
  slt_pkg::slt_cell_out_t cells [N];
  slt_pkg::slt_cell_out_t lefts [N];
  slt_pkg::slt_cell_out_t rights[N];
  logic [N-1:0]           eq_vec;
  logic [N-1:0]           valid_vec;
  logic                   any_eq;
  logic                   full;

  logic [slt_pkg::CNT_W+slt_pkg::OCC_W-1:0] count_ext;

  assign in_stall = pend_r || (out_valid_r && out_stall);
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r <= in_req_type;
      val_r <= in_value;
    end
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= in_acc;
    end
  end

  // ---- cell chain ----
  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      assign eq_vec[g]    = cells[g].eq;
      assign valid_vec[g] = cells[g].valid;
      if (g == 0) begin : g_head
        // ahead of slot 0 sits a full slot that is always below the value
        assign lefts[g] = '{valid: 1'b1, ge: 1'b0, eq: 1'b0, value: val_r};
      end else begin : g_mid
        assign lefts[g] = cells[g-1];
      end
      if (g == N - 1) begin : g_tail
        assign rights[g] = '{valid: 1'b0, ge: 1'b1, eq: 1'b0, value: cells[g].value};
      end else begin : g_body
        assign rights[g] = cells[g+1];
      end
      slt_cell u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .bcast  (bcast),
        .left   (lefts[g]),
        .right  (rights[g]),
        .cell_o (cells[g])
      );
    end
  endgenerate

  assign any_eq = |eq_vec;
  assign full   = valid_vec[N-1];

  assign bcast.value = val_r;
  assign bcast.ins   = pend_r && (req_r == slt_pkg::REQ_INSERT) && !full;
  assign bcast.del   = pend_r && (req_r == slt_pkg::REQ_DELETE) && any_eq;

  // ---- result ----
  always_comb begin
    status_nxt = slt_pkg::ST_NOT_FOUND;
    count_nxt  = count_r;
    unique case (req_r)
      slt_pkg::REQ_INSERT: begin
        if (full) begin
          status_nxt = slt_pkg::ST_FULL;
        end else begin
          status_nxt = slt_pkg::ST_DONE;
          count_nxt  = count_r + 1'b1;
        end
      end
      slt_pkg::REQ_SEARCH: begin
        if (any_eq) status_nxt = slt_pkg::ST_DONE;
      end
      slt_pkg::REQ_DELETE: begin
        if (any_eq) begin
          status_nxt = slt_pkg::ST_DONE;
          count_nxt  = count_r - 1'b1;
        end
      end
      default: begin
        status_nxt = slt_pkg::ST_NOT_FOUND;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pend_r) begin
      status_r <= status_nxt;
    end
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      if (pend_r) begin
        out_valid_r <= 1'b1;
        count_r     <= count_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // occupancy wraps to the port width for large tables
  assign count_ext     = {{slt_pkg::OCC_W{1'b0}}, count_r};
  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_occupancy = count_ext[slt_pkg::OCC_W-1:0];

  // ---- checks ----
  logic [N-1:0] valid_inc;
  assign valid_inc = valid_vec + 1'b1;

  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == 32'(count_r))
    else $error("occupancy count disagrees with slot valid bits");

  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_vec & valid_inc) == '0)
    else $error("valid slots are not a prefix of the chain");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(pend_r && out_valid_r))
    else $error("request executing while a result is still held");

  a_one_shift: assert property (@(posedge clk) disable iff (!rst_n)
    !(bcast.ins && bcast.del))
    else $error("insert and delete driven together");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |=> out_valid_r)
    else $error("executed request gave no result");

endmodule

`default_nettype wire

// ===== bench/sorted_list_table_tb.sv =====
// Self-checking testbench for the sorted list table: directed and random traffic against a shadow table.
`default_nettype none

module sorted_list_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP          = slt_pkg::CAPACITY;
  localparam int VALUE_W      = slt_pkg::VALUE_W;
  localparam int REQ_W        = slt_pkg::REQ_W;
  localparam int STATUS_W     = slt_pkg::STATUS_W;
  localparam int OCC_W        = slt_pkg::OCC_W;
  localparam int RANDOM_ITEMS = 600;
  localparam int IDLE_LIMIT   = 2000;
  localparam int MAX_SHOWN    = 10;
  localparam int SETTLE_CYCLES = 10;

  // The one code the block leaves unused
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct {
    bit                        wait_drain;
    logic [REQ_W-1:0]          kind;
    logic signed [VALUE_W-1:0] operand;
  } request_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [OCC_W-1:0]    occupancy;
  } outcome_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [REQ_W-1:0]            in_req_type = '0;
  logic signed [VALUE_W-1:0]   in_value = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [STATUS_W-1:0]         out_status;
  logic [OCC_W-1:0]            out_occupancy;

  request_t                    request_q[$];
  outcome_t                    outcome_q[$];
  logic signed [VALUE_W-1:0]   recent_vals[$];

  // Shadow of the table contents
  logic signed [VALUE_W-1:0]   shadow_slot[CAP];
  int                          shadow_count = 0;

  bit in_taken = 1'b0;
  bit settled = 1'b0;
  int queued = 0;
  int beats_in = 0;
  int beats_out = 0;
  int idle_cycles = 0;
  int mismatches = 0;
  int n_insert = 0, n_search = 0, n_delete = 0, n_unused = 0;
  int n_full = 0, n_miss = 0, peak = 0;

  sorted_list_table dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_occupancy (out_occupancy)
  );

  always #1 clk = ~clk;

  function automatic outcome_t table_apply(logic [REQ_W-1:0] kind,
                                           logic signed [VALUE_W-1:0] operand);
    outcome_t res;
    int pos;
    int i;
    res.status = slt_pkg::ST_NOT_FOUND;
    pos = -1;
    for (i = 0; i < shadow_count; i++) begin
      if (pos < 0 && shadow_slot[i] == operand) pos = i;
    end
    case (kind)
      slt_pkg::REQ_INSERT: begin
        if (shadow_count >= CAP) begin
          res.status = slt_pkg::ST_FULL;
        end else begin
          // shift larger-or-equal values up so the new one lands ahead of equals
          i = shadow_count;
          while (i > 0 && shadow_slot[i-1] >= operand) begin
            shadow_slot[i] = shadow_slot[i-1];
            i--;
          end
          shadow_slot[i] = operand;
          shadow_count++;
          res.status = slt_pkg::ST_DONE;
        end
      end
      slt_pkg::REQ_SEARCH: begin
        if (pos >= 0) res.status = slt_pkg::ST_DONE;
      end
      slt_pkg::REQ_DELETE: begin
        if (pos >= 0) begin
          for (i = pos; i < shadow_count - 1; i++) shadow_slot[i] = shadow_slot[i+1];
          shadow_count--;
          res.status = slt_pkg::ST_DONE;
        end
      end
      default: ;
    endcase
    res.occupancy = OCC_W'(shadow_count);
    return res;
  endfunction

  task automatic queue_request(logic [REQ_W-1:0] kind, logic signed [VALUE_W-1:0] operand);
    request_t r;
    r.wait_drain = 1'b0;
    r.kind       = kind;
    r.operand    = operand;
    request_q.push_back(r);
    if (kind != REQ_UNUSED) queued++;
    if (kind == slt_pkg::REQ_INSERT) begin
      recent_vals.push_back(operand);
      if (recent_vals.size() > 48) recent_vals.delete(0);
    end
  endtask

  task automatic queue_pause();
    request_t r;
    r.wait_drain = 1'b1;
    r.kind       = '0;
    r.operand    = '0;
    request_q.push_back(r);
  endtask

  function automatic logic signed [VALUE_W-1:0] any_value();
    logic signed [VALUE_W-1:0] v;
    case ($urandom_range(3))
      0:       v = $urandom;
      1:       v = $signed($urandom_range(16)) - 8;
      2:       v = 32'sh7FFF_FFFF - $urandom_range(2);
      default: v = 32'sh8000_0000 + $urandom_range(2);
    endcase
    return v;
  endfunction

  // Mostly values that were inserted lately, so searches and deletes hit
  function automatic logic signed [VALUE_W-1:0] known_value();
    if (recent_vals.size() == 0 || $urandom_range(9) == 0) return any_value();
    return recent_vals[$urandom_range(recent_vals.size() - 1)];
  endfunction

  // Stimulus and end of run
  initial begin
    int n;
    int k;
    int r;
    int base;
    bit paused;
    paused = 1'b0;

    queue_request(slt_pkg::REQ_SEARCH, 0);
    queue_request(slt_pkg::REQ_DELETE, 0);
    queue_request(slt_pkg::REQ_INSERT, 32'sh7FFF_FFFF);
    queue_request(slt_pkg::REQ_INSERT, 32'sh8000_0000);
    queue_request(slt_pkg::REQ_INSERT, 0);
    queue_request(slt_pkg::REQ_INSERT, -1);
    queue_request(slt_pkg::REQ_INSERT, 0);
    queue_request(slt_pkg::REQ_SEARCH, 32'sh8000_0000);
    queue_request(slt_pkg::REQ_SEARCH, 32'sh7FFF_FFFF);
    queue_request(slt_pkg::REQ_SEARCH, 5);
    queue_request(REQ_UNUSED, -1);
    queue_request(slt_pkg::REQ_DELETE, 0);
    queue_request(slt_pkg::REQ_DELETE, 7);
    for (k = 0; k < CAP - 4; k++) queue_request(slt_pkg::REQ_INSERT, k * 3 - 15);
    queue_request(slt_pkg::REQ_INSERT, 1);
    queue_request(slt_pkg::REQ_SEARCH, 0);
    queue_request(slt_pkg::REQ_DELETE, 32'sh7FFF_FFFF);
    queue_request(slt_pkg::REQ_DELETE, 32'sh8000_0000);
    queue_pause();

    base = queued;
    while (queued - base < RANDOM_ITEMS) begin
      if (!paused && queued - base > RANDOM_ITEMS / 2) begin
        queue_pause();
        paused = 1'b1;
      end
      case ($urandom_range(9))
        0, 1, 2: begin
          n = $urandom_range(20, 4);
          for (k = 0; k < n; k++) queue_request(slt_pkg::REQ_INSERT, any_value());
        end
        3, 4, 5: begin
          n = $urandom_range(20, 5);
          for (k = 0; k < n; k++) begin
            r = $urandom_range(9);
            if (r < 4)      queue_request(slt_pkg::REQ_SEARCH, known_value());
            else if (r < 8) queue_request(slt_pkg::REQ_DELETE, known_value());
            else            queue_request(slt_pkg::REQ_INSERT, any_value());
          end
        end
        6, 7: begin
          n = $urandom_range(18, 4);
          for (k = 0; k < n; k++) queue_request(slt_pkg::REQ_DELETE, known_value());
        end
        8: begin
          n = $urandom_range(8, 2);
          for (k = 0; k < n; k++) queue_request(REQ_W'($urandom_range(3)), $urandom);
        end
        default: begin
          n = $urandom_range(10, 3);
          for (k = 0; k < n; k++) queue_request(slt_pkg::REQ_SEARCH, any_value());
        end
      endcase
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    do @(negedge clk); while (!settled);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Ran %0d requests (%0d insert, %0d search, %0d delete, %0d unused code), %0d results",
             beats_in, n_insert, n_search, n_delete, n_unused, beats_out);
    $display("Inserts refused on a full table: %0d, misses: %0d, peak occupancy %0d",
             n_full, n_miss, peak);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Driver: present the next beat once the last one has gone
  always @(negedge clk) begin
    request_t head;
    bit steady;
    steady = (beats_in >= 250) && (beats_in < 400);
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        // hold off until every outstanding result is back
        if (request_q.size() != 0 && request_q[0].wait_drain && outcome_q.size() == 0) begin
          head = request_q.pop_front();
        end
        if (request_q.size() != 0 && !request_q[0].wait_drain &&
            (steady || $urandom_range(99) >= 38)) begin
          head = request_q.pop_front();
          in_valid    <= 1'b1;
          in_req_type <= head.kind;
          in_value    <= head.operand;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= !steady && ($urandom_range(99) < 38);
    end
  end

  // Monitor: predict on each request beat, check each result beat
  always @(posedge clk) begin
    outcome_t want;
    bit out_taken;
    in_taken = 1'b0;
    out_taken = 1'b0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        in_taken = 1'b1;
        beats_in++;
        case (in_req_type)
          slt_pkg::REQ_INSERT: n_insert++;
          slt_pkg::REQ_SEARCH: n_search++;
          slt_pkg::REQ_DELETE: n_delete++;
          default:             n_unused++;
        endcase
        want = table_apply(in_req_type, in_value);
        if (want.status == slt_pkg::ST_FULL) n_full++;
        if (want.status == slt_pkg::ST_NOT_FOUND) n_miss++;
        if (int'(want.occupancy) > peak) peak = int'(want.occupancy);
        outcome_q.push_back(want);
      end
      if (out_valid && !out_stall) begin
        out_taken = 1'b1;
        beats_out++;
        if (outcome_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("[%0t] result beat %0d with nothing outstanding: status %0d occupancy %0d",
                     $realtime, beats_out, out_status, out_occupancy);
        end else begin
          want = outcome_q.pop_front();
          if (out_status !== want.status || out_occupancy !== want.occupancy) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
              $display("[%0t] result beat %0d: status exp %0d got %0d, occupancy exp %0d got %0d",
                       $realtime, beats_out, want.status, out_status,
                       want.occupancy, out_occupancy);
          end
        end
      end
      idle_cycles = (in_taken || out_taken) ? 0 : idle_cycles + 1;
      settled = (request_q.size() == 0) && !(in_valid && !in_taken) && (outcome_q.size() == 0);
    end
  end

  // Watchdog: give up when nothing moves for too long
  always @(negedge clk) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no beat moved for %0d cycles", IDLE_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/core/slt_pkg.sv
rtl/core/slt_cell.sv
rtl/core/sorted_list_table.sv
bench/sorted_list_table_tb.sv
